### rtl/ansi_text_console_core_defines.svh
// Assertion macros shared by the console checker.
`ifndef ANSI_TEXT_CONSOLE_CORE_DEFINES_SVH
`define ANSI_TEXT_CONSOLE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ATC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ATC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/atc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package atc_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;
    localparam int SEQ_DEPTH      = 15;

    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 4;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int KIND_W  = 2;
    localparam int TDATA_W = 32;
    localparam int TDATA_PAD_W = TDATA_W - (ROW_W + COL_W + 2 * COLOR_W + CHAR_W);

    localparam int SEQ_IDX_W  = $clog2(SEQ_DEPTH);
    localparam int SEQ_FILL_W = $clog2(SEQ_DEPTH + 1);
    localparam int MAG_W      = 10;

    localparam int RESULT_CAP = 20;
    localparam int COUNT_W    = $clog2(RESULT_CAP + 1);

    localparam int OVF_LEN   = 18;
    localparam int OVF_IDX_W = $clog2(OVF_LEN);

    localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL       = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_LOWER_C  = 8'h63;
    localparam logic [CHAR_W-1:0] CH_LOWER_M  = 8'h6D;

    localparam logic [COLOR_W-1:0] FORE_DEFAULT = 4'd7;
    localparam logic [COLOR_W-1:0] BACK_DEFAULT = 4'd0;

    localparam logic [MAG_W-1:0] MAG_LIMIT   = 10'd100;
    localparam logic [MAG_W-1:0] SGR_FORE_LO = 10'd30;
    localparam logic [MAG_W-1:0] SGR_FORE_HI = 10'd37;
    localparam logic [MAG_W-1:0] SGR_BACK_LO = 10'd40;
    localparam logic [MAG_W-1:0] SGR_BACK_HI = 10'd47;

    typedef logic [COL_W:0] col_ext_t;
    typedef logic [ROW_W:0] row_ext_t;

    typedef enum logic [KIND_W-1:0] {
        EV_GLYPH  = 2'd0,
        EV_SCROLL = 2'd1,
        EV_CLEAR  = 2'd2
    } event_t;

    typedef enum logic [1:0] {
        PH_TEXT,
        PH_ESC,
        PH_SEQ
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEXT,
        ST_SCROLL,
        ST_CLEAR,
        ST_SGR,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        SC_BLANK,
        SC_DIGITS,
        SC_SKIP
    } scan_t;

    typedef struct packed {
        event_t              kind;
        logic [CHAR_W-1:0]   glyph;
        logic [COLOR_W-1:0]  fore;
        logic [COLOR_W-1:0]  back;
        logic [COL_W-1:0]    col;
        logic [ROW_W-1:0]    row;
    } result_t;

    typedef struct packed {
        logic step;
        logic home;
    } cur_ctrl_t;

    typedef struct packed {
        logic              glyph_emit;
        logic              scroll_emit;
        logic              is_esc;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
    } cur_stat_t;

    typedef struct packed {
        logic clear;
        logic write;
        logic start;
    } sgr_ctrl_t;

    typedef struct packed {
        logic               full;
        logic               done;
        logic               set_default;
        logic               set_fore;
        logic               set_back;
        logic [COLOR_W-1:0] color;
    } sgr_stat_t;

    // SGR color index 0..7 to VGA attribute color
    function automatic logic [COLOR_W-1:0] sgr_color(input logic [2:0] code);
        logic [COLOR_W-1:0] c;
        case (code)
            3'd0:    c = 4'd0;
            3'd1:    c = 4'd4;
            3'd2:    c = 4'd2;
            3'd3:    c = 4'd14;
            3'd4:    c = 4'd1;
            3'd5:    c = 4'd5;
            3'd6:    c = 4'd3;
            default: c = 4'd15;
        endcase
        return c;
    endfunction

    // "Buffer overflowed" followed by a newline
    function automatic logic [CHAR_W-1:0] overflow_char(input logic [OVF_IDX_W-1:0] idx);
        logic [CHAR_W-1:0] ch;
        case (idx)
            5'd0:    ch = 8'h42;
            5'd1:    ch = 8'h75;
            5'd2:    ch = 8'h66;
            5'd3:    ch = 8'h66;
            5'd4:    ch = 8'h65;
            5'd5:    ch = 8'h72;
            5'd6:    ch = 8'h20;
            5'd7:    ch = 8'h6F;
            5'd8:    ch = 8'h76;
            5'd9:    ch = 8'h65;
            5'd10:   ch = 8'h72;
            5'd11:   ch = 8'h66;
            5'd12:   ch = 8'h6C;
            5'd13:   ch = 8'h6F;
            5'd14:   ch = 8'h77;
            5'd15:   ch = 8'h65;
            5'd16:   ch = 8'h64;
            default: ch = CH_NL;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### rtl/ansi_text_console_core.sv
// Character console for an 80x25 text screen with a small ANSI color parser.
// Each accepted byte on the slave stream yields zero or more items on the
// master stream: glyph writes (with colors and position), one-line scrolls
// and screen clears; tlast marks the final item of a byte. A plain byte is
// accepted, then passes once through the cursor unit; a glyph that scrolls
// adds a scroll item and a flush of the one-item hold register; a newline
// that scrolls adds the scroll item. ESC goes through the cursor unit, ESC
// 'c' through the clear state; '[' and stored sequence bytes need only
// acceptance. The closing 'm' waits for the field scanner, which reads one
// stored byte per cycle. A sequence overflow walks the 18-character message
// through the cursor unit, one character per cycle unless stalled, plus its
// scroll items and a final flush. Results wait in an output register, so a
// stalled master side holds the sequencer only when a second result is due.
`timescale 1ns / 1ps
`default_nettype none

module ansi_text_console_core
    import atc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // [7:0] char_byte
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // [7:0] glyph, [11:8] fore_color, [15:12] back_color, [22:16] column,
    // [27:23] row, [31:28] zero
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [KIND_W-1:0]       m_tuser,   // [1:0] event_kind
    output logic                    m_tlast    // last_event
);

    state_t                state_reg;
    state_t                state_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [CHAR_W-1:0]     byte_reg;
    logic [CHAR_W-1:0]     byte_next;
    logic                  walk_reg;
    logic                  walk_next;
    logic [OVF_IDX_W-1:0]  idx_reg;
    logic [OVF_IDX_W-1:0]  idx_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [COLOR_W-1:0]    fore_reg;
    logic [COLOR_W-1:0]    fore_next;
    logic [COLOR_W-1:0]    back_reg;
    logic [COLOR_W-1:0]    back_next;
    result_t               out_reg;
    result_t               out_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_last_reg;
    logic                  out_last_next;
    result_t               hold_reg;
    result_t               hold_next;
    logic                  hold_valid_reg;
    logic                  hold_valid_next;

    cur_ctrl_t             cur_ctrl;
    cur_stat_t             cur_stat;
    sgr_ctrl_t             sgr_ctrl;
    sgr_stat_t             sgr_stat;
    logic [CHAR_W-1:0]     text_char;

    logic                  out_free;
    logic                  capped;
    logic                  push_req;
    logic                  push_final;
    logic                  push_ok;
    logic                  will_hold;
    logic                  walk_more;
    result_t               push_res;

    assign text_char = walk_reg ? overflow_char(idx_reg) : byte_reg;

    atc_cursor u_cursor (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (cur_ctrl),
        .ch    (text_char),
        .stat  (cur_stat)
    );

    atc_sgr u_sgr (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (sgr_ctrl),
        .wr_data (s_tdata),
        .stat    (sgr_stat)
    );

    always_comb
    begin
        out_free  = !out_valid_reg || m_tready;
        capped    = (count_reg >= COUNT_W'(RESULT_CAP));
        walk_more = walk_reg && (idx_reg != OVF_IDX_W'(OVF_LEN - 1));

        push_req   = ((state_reg == ST_TEXT) && cur_stat.glyph_emit)
                     || (state_reg == ST_SCROLL) || (state_reg == ST_CLEAR);
        push_final = !walk_reg && ((state_reg == ST_CLEAR) || (state_reg == ST_SCROLL)
                     || ((state_reg == ST_TEXT) && !cur_stat.scroll_emit));
        push_ok    = capped || (!hold_valid_reg && !push_final) || out_free;
        will_hold  = hold_valid_reg || (push_req && !capped && !push_final);

        push_res = '0;
        case (state_reg)
            ST_TEXT:
            begin
                push_res.kind  = EV_GLYPH;
                push_res.glyph = text_char;
                push_res.fore  = fore_reg;
                push_res.back  = back_reg;
                push_res.col   = cur_stat.col;
                push_res.row   = cur_stat.row;
            end
            ST_SCROLL:
            begin
                push_res.kind = EV_SCROLL;
            end
            ST_CLEAR:
            begin
                push_res.kind = EV_CLEAR;
            end
            default:
            begin
                push_res.kind = EV_GLYPH;
            end
        endcase

        state_next      = state_reg;
        phase_next      = phase_reg;
        byte_next       = byte_reg;
        walk_next       = walk_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        fore_next       = fore_reg;
        back_next       = back_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        cur_ctrl        = '0;
        sgr_ctrl        = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next  = s_tdata;
                    count_next = '0;
                    walk_next  = 1'b0;
                    idx_next   = '0;
                    case (phase_reg)
                        PH_SEQ:
                        begin
                            if (s_tdata == CH_LOWER_M)
                            begin
                                sgr_ctrl.start = 1'b1;
                                phase_next     = PH_TEXT;
                                state_next     = ST_SGR;
                            end
                            else if (sgr_stat.full)
                            begin
                                // drop the sequence and print the overflow message
                                phase_next = PH_TEXT;
                                walk_next  = 1'b1;
                                state_next = ST_TEXT;
                            end
                            else
                            begin
                                sgr_ctrl.write = 1'b1;
                            end
                        end
                        PH_ESC:
                        begin
                            if (s_tdata == CH_LBRACKET)
                            begin
                                phase_next     = PH_SEQ;
                                sgr_ctrl.clear = 1'b1;
                            end
                            else if (s_tdata == CH_LOWER_C)
                            begin
                                cur_ctrl.home = 1'b1;
                                fore_next     = FORE_DEFAULT;
                                back_next     = BACK_DEFAULT;
                                phase_next    = PH_TEXT;
                                state_next    = ST_CLEAR;
                            end
                            else
                            begin
                                phase_next = PH_TEXT;
                                state_next = ST_TEXT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_TEXT;
                        end
                    endcase
                end
            end
            ST_TEXT:
            begin
                if (!push_req || push_ok)
                begin
                    cur_ctrl.step = 1'b1;
                    if (cur_stat.is_esc)
                    begin
                        phase_next = PH_ESC;
                    end
                    if (cur_stat.scroll_emit)
                    begin
                        state_next = ST_SCROLL;
                    end
                    else if (walk_more)
                    begin
                        idx_next = idx_reg + OVF_IDX_W'(1);
                    end
                    else
                    begin
                        state_next = will_hold ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_SCROLL:
            begin
                if (push_ok)
                begin
                    if (walk_more)
                    begin
                        idx_next   = idx_reg + OVF_IDX_W'(1);
                        state_next = ST_TEXT;
                    end
                    else
                    begin
                        state_next = will_hold ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                if (push_ok)
                begin
                    state_next = will_hold ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_SGR:
            begin
                if (sgr_stat.set_default)
                begin
                    fore_next = FORE_DEFAULT;
                    back_next = BACK_DEFAULT;
                end
                if (sgr_stat.set_fore)
                begin
                    fore_next = sgr_stat.color;
                end
                if (sgr_stat.set_back)
                begin
                    back_next = sgr_stat.color;
                end
                if (sgr_stat.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = hold_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // results past the cap are dropped; the held one then closes the item
        if (push_req && push_ok && !capped)
        begin
            count_next = count_reg + COUNT_W'(1);
            if (hold_valid_reg)
            begin
                out_next       = hold_reg;
                out_last_next  = 1'b0;
                out_valid_next = 1'b1;
                hold_next      = push_res;
            end
            else if (push_final)
            begin
                out_next       = push_res;
                out_last_next  = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                hold_next       = push_res;
                hold_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_TEXT;
            walk_reg       <= 1'b0;
            idx_reg        <= '0;
            count_reg      <= '0;
            fore_reg       <= FORE_DEFAULT;
            back_reg       <= BACK_DEFAULT;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            walk_reg       <= walk_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            fore_reg       <= fore_next;
            back_reg       <= back_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        hold_reg     <= hold_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{TDATA_PAD_W{1'b0}}, out_reg.row, out_reg.col, out_reg.back,
                       out_reg.fore, out_reg.glyph};

endmodule

`default_nettype wire

### rtl/atc_cursor.sv
`timescale 1ns / 1ps
`default_nettype none

module atc_cursor
    import atc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cur_ctrl_t         ctrl,
    input  wire logic [CHAR_W-1:0] ch,
    output cur_stat_t              stat
);

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic     is_nl;
    logic     is_esc;
    logic     is_glyph;
    logic     scroll;
    col_ext_t col_step;
    row_ext_t row_step;

    always_comb
    begin
        is_nl    = (ch == CH_NL);
        is_esc   = (ch == CH_ESC);
        is_glyph = !is_nl && !is_esc;

        col_step = {1'b0, col_reg} + col_ext_t'(is_glyph);
        row_step = {1'b0, row_reg} + row_ext_t'(is_nl);
        if (is_nl)
        begin
            col_step = '0;
        end
        // wrap at the right edge
        if (col_step >= col_ext_t'(SCREEN_COLUMNS))
        begin
            col_step = '0;
            row_step = row_step + row_ext_t'(1);
        end
        // hold on the bottom row and scroll
        scroll = 1'b0;
        if (row_step >= row_ext_t'(SCREEN_ROWS))
        begin
            row_step = row_ext_t'(SCREEN_ROWS - 1);
            scroll   = 1'b1;
        end

        col_next = col_reg;
        row_next = row_reg;
        if (ctrl.home)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (ctrl.step)
        begin
            col_next = col_step[COL_W-1:0];
            row_next = row_step[ROW_W-1:0];
        end

        stat.glyph_emit  = is_glyph;
        stat.scroll_emit = scroll;
        stat.is_esc      = is_esc;
        stat.col         = col_reg;
        stat.row         = row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

### rtl/atc_sgr.sv
`timescale 1ns / 1ps
`default_nettype none

module atc_sgr
    import atc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sgr_ctrl_t         ctrl,
    input  wire logic [CHAR_W-1:0] wr_data,
    output sgr_stat_t              stat
);

    logic [CHAR_W-1:0] seq_mem [SEQ_DEPTH];

    logic [SEQ_FILL_W-1:0] fill_reg;
    logic [SEQ_FILL_W-1:0] fill_next;
    logic [SEQ_FILL_W-1:0] pos_reg;
    logic [SEQ_FILL_W-1:0] pos_next;
    logic                  busy_reg;
    logic                  busy_next;
    scan_t                 scan_reg;
    scan_t                 scan_next;
    logic                  neg_reg;
    logic                  neg_next;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      mag_next;

    logic [CHAR_W-1:0] rd_byte_reg;
    logic              at_end;
    logic              field_end;
    logic              is_blank;
    logic              is_sign;
    logic              is_digit;
    logic [MAG_W-1:0]  digit;
    logic [MAG_W-1:0]  mag_x10;
    logic [MAG_W-1:0]  fore_off;
    logic [MAG_W-1:0]  back_off;

    always_ff @(posedge clk)
    begin
        if (ctrl.write)
        begin
            seq_mem[fill_reg[SEQ_IDX_W-1:0]] <= wr_data;
        end
        // fetch the byte the scanner looks at in the next cycle
        rd_byte_reg <= seq_mem[pos_next[SEQ_IDX_W-1:0]];
    end

    always_comb
    begin
        at_end    = (pos_reg == fill_reg);
        field_end = at_end || (rd_byte_reg == CH_SEMI);
        is_blank  = rd_byte_reg inside {CH_SPACE, [CH_TAB:CH_CR]};
        is_sign   = (rd_byte_reg == CH_PLUS) || (rd_byte_reg == CH_MINUS);
        is_digit  = rd_byte_reg inside {[CH_ZERO:CH_NINE]};
        digit     = {{(MAG_W-4){1'b0}}, rd_byte_reg[3:0]};
        mag_x10   = (mag_reg << 3) + (mag_reg << 1) + digit;
        fore_off  = mag_reg - SGR_FORE_LO;
        back_off  = mag_reg - SGR_BACK_LO;

        fill_next = fill_reg;
        pos_next  = pos_reg;
        busy_next = busy_reg;
        scan_next = scan_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;

        stat             = '0;
        stat.full        = (fill_reg >= SEQ_FILL_W'(SEQ_DEPTH));

        if (busy_reg)
        begin
            pos_next = pos_reg + SEQ_FILL_W'(1);
            if (field_end)
            begin
                if (mag_reg == '0)
                begin
                    stat.set_default = 1'b1;
                end
                else if (!neg_reg && (mag_reg inside {[SGR_FORE_LO:SGR_FORE_HI]}))
                begin
                    stat.set_fore = 1'b1;
                    stat.color    = sgr_color(fore_off[2:0]);
                end
                else if (!neg_reg && (mag_reg inside {[SGR_BACK_LO:SGR_BACK_HI]}))
                begin
                    stat.set_back = 1'b1;
                    stat.color    = sgr_color(back_off[2:0]);
                end
                scan_next = SC_BLANK;
                mag_next  = '0;
                neg_next  = 1'b0;
                if (at_end)
                begin
                    busy_next = 1'b0;
                    stat.done = 1'b1;
                end
            end
            else
            begin
                case (scan_reg)
                    SC_BLANK:
                    begin
                        if (is_blank)
                        begin
                            scan_next = SC_BLANK;
                        end
                        else if (is_sign)
                        begin
                            neg_next  = (rd_byte_reg == CH_MINUS);
                            scan_next = SC_DIGITS;
                        end
                        else if (is_digit)
                        begin
                            mag_next  = digit;
                            scan_next = SC_DIGITS;
                        end
                        else
                        begin
                            scan_next = SC_SKIP;
                        end
                    end
                    SC_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            // saturate: stop growing once the magnitude reaches 100 or more
                            if (mag_reg < MAG_LIMIT)
                            begin
                                mag_next = mag_x10;
                            end
                        end
                        else
                        begin
                            scan_next = SC_SKIP;
                        end
                    end
                    default:
                    begin
                        scan_next = SC_SKIP;
                    end
                endcase
            end
        end

        if (ctrl.start)
        begin
            busy_next = 1'b1;
            pos_next  = '0;
            scan_next = SC_BLANK;
            mag_next  = '0;
            neg_next  = 1'b0;
        end

        if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.write)
        begin
            fill_next = fill_reg + SEQ_FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            pos_reg  <= '0;
            busy_reg <= 1'b0;
            scan_reg <= SC_BLANK;
            neg_reg  <= 1'b0;
            mag_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            pos_reg  <= pos_next;
            busy_reg <= busy_next;
            scan_reg <= scan_next;
            neg_reg  <= neg_next;
            mag_reg  <= mag_next;
        end
    end

endmodule

`default_nettype wire

### rtl/atc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "ansi_text_console_core_defines.svh"

module atc_checker
    import atc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [7:0]         s_tdata,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]  m_tuser,
    input wire logic               m_tlast
);

    `ATC_ASSERT_NOW(a_in_known, s_tvalid && s_tready, !$isunknown(s_tdata), "accepted byte has unknown bits")

    `ATC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output item changed")

    `ATC_ASSERT_NOW(a_ctrl_zero, m_tvalid && (m_tuser != EV_GLYPH), m_tdata == '0, "scroll or clear item carries payload")

    `ATC_ASSERT_NOW(a_pos_range, m_tvalid && (m_tuser == EV_GLYPH), (m_tdata[22:16] < COL_W'(SCREEN_COLUMNS)) && (m_tdata[27:23] < ROW_W'(SCREEN_ROWS)), "glyph written off screen")

    `ATC_ASSERT_NOW(a_clear_alone, m_tvalid && (m_tuser == EV_CLEAR), m_tlast, "clear item not last of its byte")

endmodule

bind ansi_text_console_core atc_checker u_atc_checker (.*);

`default_nettype wire

### verif/tb_ansi_text_console_core.sv
`timescale 1ns / 1ps

module tb_ansi_text_console_core;
    import atc_pkg::*;

    typedef struct {
        event_t             kind;
        logic [CHAR_W-1:0]  glyph;
        logic [COLOR_W-1:0] fore;
        logic [COLOR_W-1:0] back;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               last;
    } console_event_t;

    class console_scoreboard;
        phase_t             esc_phase;
        int                 cur_col;
        int                 cur_row;
        logic [COLOR_W-1:0] cur_fore;
        logic [COLOR_W-1:0] cur_back;
        logic [CHAR_W-1:0]  seq_buf [SEQ_DEPTH];
        int                 seq_fill;
        logic [COLOR_W-1:0] vga_palette [8];
        string              overflow_msg;
        console_event_t     byte_events [$];
        console_event_t     pending_events [$];
        int                 bytes_seen;
        int                 events_checked;
        int                 scrolls_seen;
        int                 clears_seen;
        int                 sgr_count;
        int                 overflow_count;
        int                 mismatches;

        function new();
            vga_palette = '{4'd0, 4'd4, 4'd2, 4'd14, 4'd1, 4'd5, 4'd3, 4'd15};
            overflow_msg = "Buffer overflowed\n";
            esc_phase = PH_TEXT;
            cur_col = 0;
            cur_row = 0;
            cur_fore = FORE_DEFAULT;
            cur_back = BACK_DEFAULT;
            seq_fill = 0;
            bytes_seen = 0;
            events_checked = 0;
            scrolls_seen = 0;
            clears_seen = 0;
            sgr_count = 0;
            overflow_count = 0;
            mismatches = 0;
        endfunction

        function void emit(event_t kind, logic [CHAR_W-1:0] g, logic [COLOR_W-1:0] f,
                           logic [COLOR_W-1:0] b, int c, int r);
            console_event_t ev;
            ev.kind  = kind;
            ev.glyph = g;
            ev.fore  = f;
            ev.back  = b;
            ev.col   = c[COL_W-1:0];
            ev.row   = r[ROW_W-1:0];
            ev.last  = 1'b0;
            // drop anything past the per-byte cap
            if (byte_events.size() < RESULT_CAP)
                byte_events.push_back(ev);
        endfunction

        function void put_char(logic [CHAR_W-1:0] c);
            if (c == CH_NL) begin
                cur_col = 0;
                cur_row++;
            end else if (c == CH_ESC) begin
                esc_phase = PH_ESC;
            end else begin
                emit(EV_GLYPH, c, cur_fore, cur_back, cur_col, cur_row);
                cur_col++;
            end
            if (cur_col >= SCREEN_COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
            if (cur_row >= SCREEN_ROWS) begin
                cur_row = SCREEN_ROWS - 1;
                emit(EV_SCROLL, '0, '0, '0, 0, 0);
            end
        endfunction

        function bit is_blank(logic [CHAR_W-1:0] b);
            return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        endfunction

        function bit is_digit(logic [CHAR_W-1:0] b);
            return (b >= CH_ZERO && b <= CH_NINE);
        endfunction

        // Parse one field the way atoi does, saturating the magnitude.
        function void apply_sgr_field(int start, int stop);
            int i;
            int mag;
            bit neg;
            i = start;
            mag = 0;
            neg = 1'b0;
            while (i < stop && is_blank(seq_buf[i]))
                i++;
            if (i < stop && (seq_buf[i] == CH_PLUS || seq_buf[i] == CH_MINUS)) begin
                neg = (seq_buf[i] == CH_MINUS);
                i++;
            end
            while (i < stop && is_digit(seq_buf[i])) begin
                if (mag < MAG_LIMIT)
                    mag = mag * 10 + int'(seq_buf[i] - CH_ZERO);
                i++;
            end
            if (mag == 0) begin
                cur_fore = FORE_DEFAULT;
                cur_back = BACK_DEFAULT;
            end else if (!neg && mag >= SGR_FORE_LO && mag <= SGR_FORE_HI) begin
                cur_fore = vga_palette[mag - SGR_FORE_LO];
            end else if (!neg && mag >= SGR_BACK_LO && mag <= SGR_BACK_HI) begin
                cur_back = vga_palette[mag - SGR_BACK_LO];
            end
        endfunction

        function void apply_sgr();
            int pos;
            int st;
            pos = 0;
            do begin
                st = pos;
                while (pos < seq_fill && seq_buf[pos] != CH_SEMI)
                    pos++;
                apply_sgr_field(st, pos);
                pos++;
            end while (pos <= seq_fill);
        endfunction

        function void note_byte(logic [CHAR_W-1:0] c);
            byte_events.delete();
            bytes_seen++;
            case (esc_phase)
                PH_SEQ: begin
                    if (c == CH_LOWER_M) begin
                        apply_sgr();
                        sgr_count++;
                        esc_phase = PH_TEXT;
                    end else if (seq_fill >= SEQ_DEPTH) begin
                        esc_phase = PH_TEXT;
                        overflow_count++;
                        for (int k = 0; k < overflow_msg.len(); k++)
                            put_char(overflow_msg[k]);
                    end else begin
                        seq_buf[seq_fill] = c;
                        seq_fill++;
                    end
                end
                PH_ESC: begin
                    if (c == CH_LBRACKET) begin
                        esc_phase = PH_SEQ;
                        seq_fill = 0;
                    end else if (c == CH_LOWER_C) begin
                        cur_col = 0;
                        cur_row = 0;
                        cur_fore = FORE_DEFAULT;
                        cur_back = BACK_DEFAULT;
                        esc_phase = PH_TEXT;
                        emit(EV_CLEAR, '0, '0, '0, 0, 0);
                    end else begin
                        esc_phase = PH_TEXT;
                        put_char(c);
                    end
                end
                default: put_char(c);
            endcase
            if (byte_events.size() > 0)
                byte_events[byte_events.size() - 1].last = 1'b1;
            foreach (byte_events[k])
                pending_events.push_back(byte_events[k]);
        endfunction

        function void check_event(logic [TDATA_W-1:0] data, logic [KIND_W-1:0] user,
                                  logic lst);
            console_event_t exp_ev;
            console_event_t got;
            got.kind  = event_t'(user);
            got.glyph = data[7:0];
            got.fore  = data[11:8];
            got.back  = data[15:12];
            got.col   = data[22:16];
            got.row   = data[27:23];
            got.last  = lst;
            events_checked++;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event %0d: kind %0d glyph %h col %0d row %0d",
                             events_checked, got.kind, got.glyph, got.col, got.row);
                return;
            end
            exp_ev = pending_events.pop_front();
            if (got.kind == EV_SCROLL)
                scrolls_seen++;
            if (got.kind == EV_CLEAR)
                clears_seen++;
            if (got.kind != exp_ev.kind || got.glyph != exp_ev.glyph
                || got.fore != exp_ev.fore || got.back != exp_ev.back
                || got.col != exp_ev.col || got.row != exp_ev.row
                || got.last != exp_ev.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("event %0d mismatch (exp/got): kind %0d/%0d glyph %h/%h",
                             events_checked, exp_ev.kind, got.kind, exp_ev.glyph, got.glyph);
                    $display("    fore %0d/%0d back %0d/%0d col %0d/%0d row %0d/%0d last %b/%b",
                             exp_ev.fore, got.fore, exp_ev.back, got.back,
                             exp_ev.col, got.col, exp_ev.row, got.row, exp_ev.last, got.last);
                end
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]  m_tuser;
    logic               m_tlast;

    console_scoreboard  sb = new();
    logic [CHAR_W-1:0]  char_stream [$];
    int                 burst_left = 0;
    int                 rx_cycle = 0;
    int                 rx_mode = 0;
    int                 hold_left = 0;
    bit                 hold_done = 1'b0;

    ansi_text_console_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_byte(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_event(m_tdata, m_tuser, m_tlast);
        end
    end

    // Receiver: switch among random stall patterns, with one long hold-off.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && sb.events_checked >= 60) begin
            hold_done = 1'b1;
            hold_left = 400;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_cycle % 7) >= 3);
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic push_number(input int v);
        string s;
        s = $sformatf("%0d", v);
        for (int k = 0; k < s.len(); k++)
            char_stream.push_back(s[k]);
    endtask

    task automatic push_text_char();
        int pick;
        logic [7:0] b;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            b = 8'($urandom_range(8'h20, 8'h7E));
        end else if (pick < 9) begin
            b = 8'($urandom_range(8'h80, 8'hFF));
        end else begin
            // control bytes other than newline and escape print as glyphs
            do
                b = 8'($urandom_range(8'h00, 8'h1F));
            while (b == CH_NL || b == CH_ESC);
        end
        char_stream.push_back(b);
    endtask

    task automatic push_sgr_sequence();
        int nfields;
        int style;
        int v;
        char_stream.push_back(CH_ESC);
        char_stream.push_back(CH_LBRACKET);
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
            if (f > 0)
                char_stream.push_back(CH_SEMI);
            style = $urandom_range(0, 9);
            if (style == 0)
                continue;
            if ($urandom_range(0, 4) == 0)
                char_stream.push_back(($urandom_range(0, 1) == 0) ? CH_SPACE
                                      : 8'($urandom_range(CH_TAB, CH_CR)));
            if ($urandom_range(0, 5) == 0)
                char_stream.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_MINUS);
            if ($urandom_range(0, 7) == 0)
                char_stream.push_back(CH_ZERO);
            if (style <= 3)
                v = SGR_FORE_LO + $urandom_range(0, 7);
            else if (style <= 6)
                v = SGR_BACK_LO + $urandom_range(0, 7);
            else if (style == 7)
                v = 0;
            else if (style == 8)
                v = $urandom_range(0, 60);
            else
                v = $urandom_range(0, 99999);
            push_number(v);
            // trailing junk ends the digits early
            if ($urandom_range(0, 7) == 0)
                char_stream.push_back(8'h78);
        end
        char_stream.push_back(CH_LOWER_M);
    endtask

    task automatic push_overflow_sequence();
        logic [7:0] b;
        char_stream.push_back(CH_ESC);
        char_stream.push_back(CH_LBRACKET);
        for (int k = 0; k <= SEQ_DEPTH; k++) begin
            case ($urandom_range(0, 3))
                0:       b = 8'($urandom_range(CH_ZERO, CH_NINE));
                1:       b = CH_SEMI;
                default: begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == CH_LOWER_M);
                end
            endcase
            char_stream.push_back(b);
        end
    endtask

    task automatic build_stimulus();
        int seg;
        int n;
        logic [7:0] b;
        // extremes, escape re-entry, clear, and two color sequences with
        // blanks, signs and an empty field
        char_stream = '{8'h00, 8'hFF, CH_NL, CH_ESC, CH_ESC, 8'h5A, CH_ESC, CH_LOWER_C,
                        CH_ESC, CH_LBRACKET, CH_SPACE, CH_MINUS, 8'h33, 8'h31, CH_SEMI,
                        CH_SEMI, 8'h34, 8'h37, CH_LOWER_M, CH_ESC, CH_LBRACKET, CH_PLUS,
                        8'h33, 8'h36, CH_LOWER_M};
        n = char_stream.size();
        while (char_stream.size() < n + 480) begin
            seg = $urandom_range(0, 99);
            if (seg < 30) begin
                repeat ($urandom_range(1, 8)) push_text_char();
            end else if (seg < 50) begin
                char_stream.push_back(CH_NL);
            end else if (seg < 72) begin
                push_sgr_sequence();
            end else if (seg < 78) begin
                push_overflow_sequence();
            end else if (seg < 83) begin
                char_stream.push_back(CH_ESC);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_LBRACKET);
                char_stream.push_back(b);
            end else if (seg < 85) begin
                char_stream.push_back(CH_ESC);
                char_stream.push_back(CH_LOWER_C);
            end else if (seg < 97) begin
                char_stream.push_back(8'($urandom_range(0, 255)));
            end else begin
                // long line to force a wrap
                repeat ($urandom_range(70, 90)) push_text_char();
            end
        end
    endtask

    initial
    begin
        build_stimulus();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (char_stream[k])
            send_byte(char_stream[k]);
        s_tvalid <= 1'b0;
        while (sb.pending_events.size() != 0)
            @(posedge clk);
        // let a closing 'm' or trailing work drain
        repeat (60) @(posedge clk);
        foreach (sb.pending_events[k]) begin
            sb.mismatches++;
            if (sb.mismatches <= 10)
                $display("missing event: kind %0d glyph %h col %0d row %0d",
                         sb.pending_events[k].kind, sb.pending_events[k].glyph,
                         sb.pending_events[k].col, sb.pending_events[k].row);
        end
        $display("Run: %0d bytes in, %0d events out (%0d scrolls, %0d clears)",
                 sb.bytes_seen, sb.events_checked, sb.scrolls_seen, sb.clears_seen);
        $display("     %0d color sequences closed, %0d sequence overflows, %0d mismatches",
                 sb.sgr_count, sb.overflow_count, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout waiting for the console to drain");
        $display("FAILED: results differ");
        $finish;
    end

endmodule
